FILE: design/sle_pkg.sv
package sle_pkg;

  localparam int LetterW    = 8;
  localparam int DigitW     = 3;
  localparam int HeldW      = 3;
  localparam int DigitSlots = 6;

  localparam logic [HeldW-1:0]   HeldEmpty = 3'd0;
  localparam logic [HeldW-1:0]   HeldOne   = 3'd1;
  localparam logic [HeldW-1:0]   HeldFull  = 3'd7;
  localparam logic [DigitW-1:0]  DigitNone = 3'd0;

  localparam logic [LetterW-1:0] CharUpperA = 8'h41;
  localparam logic [LetterW-1:0] CharUpperZ = 8'h5a;
  localparam logic [LetterW-1:0] CharLowerA = 8'h61;
  localparam logic [LetterW-1:0] CharLowerZ = 8'h7a;
  localparam logic [LetterW-1:0] CaseOffset = 8'h20;

  typedef logic [DigitW-1:0]                  digit_t;
  typedef logic [DigitSlots-1:0][DigitW-1:0]  digits_t;

  typedef struct packed {
    logic               is_letter;
    logic [LetterW-1:0] folded;
    digit_t             digit;
  } letter_info_t;

  typedef struct packed {
    logic [LetterW-1:0] lead;
    digits_t            digits;
  } code_t;

  // Soundex digit for a..z by alphabet position, 0 for skipped letters
  function automatic digit_t soundex_digit(input logic [4:0] idx);
    digit_t d;
    unique case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                        d = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23,
      5'd25:                                           d = 3'd2;
      5'd3, 5'd19:                                     d = 3'd3;
      5'd11:                                           d = 3'd4;
      5'd12, 5'd13:                                    d = 3'd5;
      5'd17:                                           d = 3'd6;
      default:                                         d = DigitNone;
    endcase
    return d;
  endfunction

endpackage

FILE: design/sle_letter_map.sv
module sle_letter_map
  import sle_pkg::*;
(
  input  logic [LetterW-1:0] letter,
  output letter_info_t       info
);

  logic [LetterW-1:0] folded;
  logic [LetterW-1:0] offset;
  logic               is_letter;

  always_comb begin
    if (letter >= CharUpperA && letter <= CharUpperZ) begin
      folded = letter + CaseOffset;
    end else begin
      folded = letter;
    end
    is_letter = (folded >= CharLowerA) && (folded <= CharLowerZ);
    offset    = folded - CharLowerA;
    info.is_letter = is_letter;
    info.folded    = folded;
    info.digit     = is_letter ? soundex_digit(offset[4:0]) : DigitNone;
  end

endmodule

FILE: design/sle_word_state.sv
module sle_word_state
  import sle_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         is_last,
  input  letter_info_t info,
  output code_t        code_next
);

  logic [HeldW-1:0]   chars_held;
  logic [HeldW-1:0]   chars_held_next;
  logic [LetterW-1:0] lead_char;
  logic [LetterW-1:0] lead_char_next;
  digits_t            code_digits;
  digits_t            code_digits_next;
  logic [HeldW-1:0]   slot;

  always_comb begin
    chars_held_next  = chars_held;
    lead_char_next   = lead_char;
    code_digits_next = code_digits;
    slot             = chars_held - HeldOne;
    if (chars_held == HeldEmpty) begin
      lead_char_next  = info.folded;
      chars_held_next = HeldOne;
    end else if (info.is_letter && info.digit != DigitNone && chars_held < HeldFull) begin
      code_digits_next[slot] = info.digit;
      chars_held_next        = chars_held + HeldOne;
    end
    code_next.lead   = lead_char_next;
    code_next.digits = code_digits_next;
  end

  // word finished: back to empty for the next word
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_held  <= HeldEmpty;
      lead_char   <= '0;
      code_digits <= '0;
    end else if (step) begin
      if (is_last) begin
        chars_held  <= HeldEmpty;
        lead_char   <= '0;
        code_digits <= '0;
      end else begin
        chars_held  <= chars_held_next;
        lead_char   <= lead_char_next;
        code_digits <= code_digits_next;
      end
    end
  end

endmodule

FILE: design/soundex_letter_encoder.sv
// Path: input register, then state update into the code register, which raises code_valid.
// Throughput: one letter per cycle while no last letter waits on a stalled code word.
// A letter that ends no word leaves no output word.
// Reset (rst, synchronous): both registers empty, word state cleared to no lead letter.
module soundex_letter_encoder
  import sle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               letter_valid,
  output logic               letter_stall,
  input  logic [LetterW-1:0] letter,
  input  logic               is_last,
  output logic               code_valid,
  input  logic               code_stall,
  output logic [LetterW-1:0] first_letter,
  output logic [DigitW-1:0]  digit_one,
  output logic [DigitW-1:0]  digit_two,
  output logic [DigitW-1:0]  digit_three,
  output logic [DigitW-1:0]  digit_four,
  output logic [DigitW-1:0]  digit_five,
  output logic [DigitW-1:0]  digit_six
);

  logic               in_vld;
  logic [LetterW-1:0] in_letter;
  logic               in_last;
  logic               advance;
  logic               out_free;
  letter_info_t       info;
  code_t              code_next;
  code_t              code_q;

  // a non-final letter never needs the code register
  assign out_free     = !code_valid || !code_stall;
  assign advance      = in_vld && (!in_last || out_free);
  assign letter_stall = in_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!letter_stall) begin
      in_vld <= letter_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!letter_stall && letter_valid) begin
      in_letter <= letter;
      in_last   <= is_last;
    end
  end

  sle_letter_map u_map (
    .letter (in_letter),
    .info   (info)
  );

  sle_word_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .is_last   (in_last),
    .info      (info),
    .code_next (code_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (out_free) begin
      code_valid <= advance && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      code_q <= code_next;
    end
  end

  assign first_letter = code_q.lead;
  assign digit_one    = code_q.digits[0];
  assign digit_two    = code_q.digits[1];
  assign digit_three  = code_q.digits[2];
  assign digit_four   = code_q.digits[3];
  assign digit_five   = code_q.digits[4];
  assign digit_six    = code_q.digits[5];

endmodule

FILE: design/sle_checker.sv
module sle_checker
  import sle_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               letter_valid,
  input logic               letter_stall,
  input logic               is_last,
  input logic               code_valid,
  input logic               code_stall,
  input logic [LetterW-1:0] first_letter,
  input logic [DigitW-1:0]  digit_one,
  input logic [DigitW-1:0]  digit_two,
  input logic [DigitW-1:0]  digit_three,
  input logic [DigitW-1:0]  digit_four,
  input logic [DigitW-1:0]  digit_five,
  input logic [DigitW-1:0]  digit_six
);

  // a fresh code word must be preceded by an accepted last letter
  a_code_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(code_valid) |-> $past(letter_valid && !letter_stall && is_last, 2))
    else $error("code word without a preceding last letter");

  // digits fill in order, so padding is only ever at the tail
  a_padding_tail: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (digit_one != DigitNone || digit_two == DigitNone) &&
                   (digit_two != DigitNone || digit_three == DigitNone) &&
                   (digit_three != DigitNone || digit_four == DigitNone) &&
                   (digit_four != DigitNone || digit_five == DigitNone) &&
                   (digit_five != DigitNone || digit_six == DigitNone))
    else $error("padding digit ahead of a coded digit");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> digit_one != HeldFull && digit_two != HeldFull &&
                   digit_three != HeldFull && digit_four != HeldFull &&
                   digit_five != HeldFull && digit_six != HeldFull)
    else $error("code digit out of range");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(first_letter) &&
                                 $stable(digit_one) && $stable(digit_six))
    else $error("stalled code word changed");

endmodule

bind soundex_letter_encoder sle_checker u_sle_checker (
  .clk          (clk),
  .rst          (rst),
  .letter_valid (letter_valid),
  .letter_stall (letter_stall),
  .is_last      (is_last),
  .code_valid   (code_valid),
  .code_stall   (code_stall),
  .first_letter (first_letter),
  .digit_one    (digit_one),
  .digit_two    (digit_two),
  .digit_three  (digit_three),
  .digit_four   (digit_four),
  .digit_five   (digit_five),
  .digit_six    (digit_six)
);

FILE: tb/sv/soundex_letter_encoder_test.sv
module soundex_letter_encoder_test
  import sle_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 400000;
  localparam int ItemsPerPhase = 470;
  localparam int Phases        = 4;
  localparam int TailCycles    = 8;

  // Tracks the word in progress and holds the codes still owed by the block
  class code_scoreboard;
    logic [HeldW-1:0]   held;
    logic [LetterW-1:0] lead;
    digits_t            digits;
    code_t              owed[$];
    int                 errors;

    function new();
      clear_word();
      errors = 0;
    endfunction

    function void clear_word();
      held   = HeldEmpty;
      lead   = '0;
      digits = '0;
    endfunction

    function digit_t letter_code(logic [LetterW-1:0] c);
      digit_t d;
      case (c)
        "b", "f", "p", "v":                     d = 3'd1;
        "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
        "d", "t":                               d = 3'd3;
        "l":                                    d = 3'd4;
        "m", "n":                               d = 3'd5;
        "r":                                    d = 3'd6;
        default:                                d = DigitNone;
      endcase
      return d;
    endfunction

    function void note_letter(logic [LetterW-1:0] raw, logic last);
      logic [LetterW-1:0] c;
      digit_t             d;
      code_t              code;
      c = (raw >= CharUpperA && raw <= CharUpperZ) ? raw + CaseOffset : raw;
      if (held == HeldEmpty) begin
        lead = c;
        held = HeldOne;
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
        d = letter_code(c);
        if (d != DigitNone && held < HeldFull) begin
          digits[int'(held) - 1] = d;
          held = held + 1'b1;
        end
      end
      if (last) begin
        code.lead   = lead;
        code.digits = digits;
        owed.insert(owed.size(), code);
        clear_word();
      end
    endfunction

    function void check_code(logic [LetterW-1:0] lead_got, digits_t got);
      code_t want;
      string names[DigitSlots];
      names = '{"digit_one", "digit_two", "digit_three", "digit_four",
                "digit_five", "digit_six"};
      if (owed.size() == 0) begin
        $error("unexpected code word, first_letter %h", lead_got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (want.lead !== lead_got) begin
        $error("first_letter: expected %h, got %h", want.lead, lead_got);
        errors++;
      end
      for (int k = 0; k < DigitSlots; k++) begin
        if (want.digits[k] !== got[k]) begin
          $error("%s: expected %0d, got %0d", names[k], want.digits[k], got[k]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               letter_valid = 1'b0;
  logic               letter_stall;
  logic [LetterW-1:0] letter       = '0;
  logic               is_last      = 1'b0;
  logic               code_valid;
  logic               code_stall   = 1'b0;
  logic [LetterW-1:0] first_letter;
  logic [DigitW-1:0]  digit_one, digit_two, digit_three;
  logic [DigitW-1:0]  digit_four, digit_five, digit_six;

  code_scoreboard sb = new();
  int             idle_pct  = 0;
  int             stall_pct = 0;
  int             sent      = 0;
  int unsigned    cycle_count = 0;

  soundex_letter_encoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .letter_valid (letter_valid),
    .letter_stall (letter_stall),
    .letter       (letter),
    .is_last      (is_last),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .first_letter (first_letter),
    .digit_one    (digit_one),
    .digit_two    (digit_two),
    .digit_three  (digit_three),
    .digit_four   (digit_four),
    .digit_five   (digit_five),
    .digit_six    (digit_six)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) begin
    code_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (code_valid && !code_stall)
        sb.check_code(first_letter, {digit_six, digit_five, digit_four,
                                     digit_three, digit_two, digit_one});
      if (letter_valid && !letter_stall)
        sb.note_letter(letter, is_last);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: failure");
    $finish;
  end

  // Entered and left just after a falling edge; valid stays high into the
  // next letter unless an idle cycle follows.
  task automatic send_letter(logic [LetterW-1:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      letter_valid <= 1'b0;
      @(negedge clk);
    end
    letter_valid <= 1'b1;
    letter       <= c;
    is_last      <= last;
    @(posedge clk);
    while (letter_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_string(string s);
    for (int k = 0; k < s.len(); k++) send_letter(s[k], k == s.len() - 1);
  endtask

  function automatic logic [LetterW-1:0] random_letter();
    return ($urandom_range(1) ? CharUpperA : CharLowerA) + LetterW'($urandom_range(25));
  endfunction

  task automatic send_random_word();
    int                 len;
    bit                 noisy;
    logic [LetterW-1:0] c;
    len   = ($urandom_range(9) == 0) ? $urandom_range(14, 8) : $urandom_range(6, 1);
    noisy = ($urandom_range(99) < 15);
    for (int k = 0; k < len; k++) begin
      if (noisy && $urandom_range(99) < 30) c = LetterW'($urandom);
      else c = random_letter();
      send_letter(c, k == len - 1);
    end
  endtask

  // Hold the sender off until every owed code has come out
  task automatic drain();
    letter_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase_idle[Phases];
    int phase_stall[Phases];
    int target;
    phase_idle  = '{0, 78, 0, 32};
    phase_stall = '{0, 0, 78, 32};

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words
    send_string("A");
    send_letter(8'h00, 1'b0);
    send_letter(8'hff, 1'b0);
    send_letter("B", 1'b1);
    send_string("bbfpvlmnr");  // equal digits kept, overflow past six dropped
    send_string("Ehwy@");      // skipped letters and a trailing non-letter
    send_string("mZ");
    send_string("@`{[");       // bytes just outside the letter ranges
    drain();

    for (int p = 0; p < Phases; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      target    = sent + ItemsPerPhase;
      while (sent < target) send_random_word();
      drain();
    end

    stall_pct = 0;
    letter_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
